// File: hdl/rdft_pkg.sv
// Shared types, constants and Taylor divisor tables for the running DFT accumulator.
package rdft_pkg;

    localparam int unsigned REQ_TYPE_W  = 1;
    localparam int unsigned FIELD_IDX_W = 2;
    localparam int unsigned POINT_IDX_W = 10;
    localparam int unsigned BIN_IDX_W   = 3;
    localparam int unsigned TIME_W      = 32;
    localparam int unsigned SAMPLE_W    = 32;
    localparam int unsigned FREQ_W      = 32;
    localparam int unsigned TRIG_W      = 16;
    localparam int unsigned ACC_W       = 48;
    localparam int unsigned CFG_IDX_W   = 2;
    localparam int unsigned CFG_DATA_W  = 32;

    localparam logic [CFG_IDX_W-1:0] REG_FREQ_START = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FREQ_STEP  = 2'd1;

    localparam logic REQ_ACCUM = 1'b0;
    localparam logic REQ_READ  = 1'b1;

    localparam logic [31:0] Q30_ONE     = 32'h4000_0000;
    localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;

    localparam logic [2:0] COS_TERMS_LAST = 3'd6;
    localparam logic [2:0] SIN_TERMS_LAST = 3'd5;

    typedef struct packed {
        logic valid;
        logic rd;
        logic hit;
    } t_tok;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_TRIG,
        ST_LAUNCH,
        ST_RUN,
        ST_FETCH
    } t_top_state;

    typedef enum logic [3:0] {
        TR_IDLE,
        TR_FRAC,
        TR_PHI,
        TR_X2,
        TR_HINIT,
        TR_H_MUL,
        TR_H_REC,
        TR_H_COR,
        TR_SMUL,
        TR_OUT
    } t_trig_state;

    // Divisor of one Horner step of the sine or cosine series.
    function automatic logic [7:0] horner_div(input logic is_sin, input logic [2:0] idx);
        logic [7:0] d;
        d = 8'd2;
        if (is_sin) begin
            case (idx)
                3'd0: d = 8'd6;
                3'd1: d = 8'd20;
                3'd2: d = 8'd42;
                3'd3: d = 8'd72;
                3'd4: d = 8'd110;
                default: d = 8'd156;
            endcase
        end else begin
            case (idx)
                3'd0: d = 8'd2;
                3'd1: d = 8'd12;
                3'd2: d = 8'd30;
                3'd3: d = 8'd56;
                3'd4: d = 8'd90;
                3'd5: d = 8'd132;
                default: d = 8'd182;
            endcase
        end
        return d;
    endfunction

    // floor(2^32 / divisor), underestimates the quotient by at most one.
    function automatic logic [31:0] horner_recip(input logic is_sin, input logic [2:0] idx);
        logic [31:0] m;
        m = 32'd2147483648;
        if (is_sin) begin
            case (idx)
                3'd0: m = 32'd715827882;
                3'd1: m = 32'd214748364;
                3'd2: m = 32'd102261126;
                3'd3: m = 32'd59652323;
                3'd4: m = 32'd39045157;
                default: m = 32'd27531841;
            endcase
        end else begin
            case (idx)
                3'd0: m = 32'd2147483648;
                3'd1: m = 32'd357913941;
                3'd2: m = 32'd143165576;
                3'd3: m = 32'd76695844;
                3'd4: m = 32'd47721858;
                3'd5: m = 32'd32537631;
                default: m = 32'd23598721;
            endcase
        end
        return m;
    endfunction

endpackage

// File: hdl/running_dft_accumulator_unit.sv
// Each request runs through the cell chain; a read then loads the output register.
// A first-of-step accumulate first runs the shared-multiplier trig sequencer.
// Results leave through a registered output; the next request is taken once one finishes.
// Reset is synchronous and active low; afterwards a clearing pass zeroes the accumulators,
// one entry per cell per cycle, with the input stalled.
// Configuration writes are taken at any time, including during the clearing pass.
module running_dft_accumulator_unit import rdft_pkg::*; #(
    parameter int NUM_BINS       = 8,
    parameter int NUM_POINTS     = 1024,
    parameter int NUM_FIELDS     = 4,
    parameter int TRIG_ADDR_BITS = 10
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [CFG_DATA_W-1:0]       i_cfg_data,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [REQ_TYPE_W-1:0]       i_req_type,
    input  logic                        i_first_of_step,
    input  logic [TIME_W-1:0]           i_time_value,
    input  logic [FIELD_IDX_W-1:0]      i_field_index,
    input  logic [POINT_IDX_W-1:0]      i_point_index,
    input  logic [BIN_IDX_W-1:0]        i_bin_index,
    input  logic signed [SAMPLE_W-1:0]  i_sample,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic signed [ACC_W-1:0]     o_real_sum,
    output logic signed [ACC_W-1:0]     o_imag_sum
);

    // Each cell owns one bin's accumulators for every (field, point) entry.
    localparam int DEPTH  = NUM_FIELDS * NUM_POINTS;
    localparam int ADDR_W = DEPTH > 1 ? $clog2(DEPTH) : 1;

    t_top_state                 r_state, n_state;
    logic [FREQ_W-1:0]          r_freq_start, r_freq_step;
    logic [TIME_W-1:0]          r_last_time;
    logic                       r_seen, r_skip;
    logic [ADDR_W-1:0]          r_clr_addr;
    logic                       r_is_read, r_in_range;
    logic [ADDR_W-1:0]          r_addr;
    logic [BIN_IDX_W-1:0]       r_bin;
    logic signed [SAMPLE_W-1:0] r_sample;
    logic                       r_o_valid;
    logic signed [ACC_W-1:0]    r_o_real, r_o_imag;

    logic accept, in_range, dup_step, trig_start, load_out;
    logic trig_push, trig_done;
    logic signed [TRIG_W-1:0] trig_cos, trig_sin;

    // Links between neighbors; index NUM_BINS is the trig-side end of the store chain.
    logic signed [TRIG_W-1:0]   cos_link [NUM_BINS+1];
    logic signed [TRIG_W-1:0]   sin_link [NUM_BINS+1];
    t_tok                       tok_link [NUM_BINS+1];
    logic [ADDR_W-1:0]          addr_link [NUM_BINS+1];
    logic [BIN_IDX_W-1:0]       bin_link [NUM_BINS+1];
    logic signed [SAMPLE_W-1:0] smp_link [NUM_BINS+1];
    logic signed [ACC_W-1:0]    re_link [NUM_BINS+1];
    logic signed [ACC_W-1:0]    im_link [NUM_BINS+1];

    assign accept   = i_valid && !o_stall;
    assign in_range = (32'(i_field_index) < NUM_FIELDS) && (32'(i_point_index) < NUM_POINTS);
    assign dup_step = r_seen && (i_time_value == r_last_time);
    // The trig sequencer starts on a new, non-repeated step time.
    assign trig_start = accept && (i_req_type == REQ_ACCUM) && i_first_of_step && !dup_step;
    assign load_out   = (r_state == ST_FETCH) && (!r_o_valid || !i_stall);

    always_comb begin
        n_state = r_state;
        o_stall = 1'b1;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == ADDR_W'(DEPTH - 1)) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    if (i_req_type == REQ_READ) begin
                        n_state = ST_LAUNCH;
                    end else if (i_first_of_step) begin
                        n_state = dup_step ? ST_IDLE : ST_TRIG;
                    end else if (!r_skip && in_range) begin
                        n_state = ST_LAUNCH;
                    end
                end
            end
            ST_TRIG: begin
                if (trig_done) n_state = r_in_range ? ST_LAUNCH : ST_IDLE;
            end
            ST_LAUNCH: n_state = ST_RUN;
            ST_RUN: begin
                // The last cell writes back in the cycle its token shows at the far end.
                if (tok_link[NUM_BINS].valid) n_state = r_is_read ? ST_FETCH : ST_IDLE;
            end
            ST_FETCH: begin
                if (load_out) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_clr_addr   <= '0;
            r_freq_start <= '0;
            r_freq_step  <= '0;
            r_last_time  <= '0;
            r_seen       <= 1'b0;
            r_skip       <= 1'b0;
            r_o_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
            end
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    REG_FREQ_START: r_freq_start <= i_cfg_data;
                    REG_FREQ_STEP:  r_freq_step  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (accept && i_req_type == REQ_ACCUM && i_first_of_step) begin
                if (dup_step) begin
                    r_skip <= 1'b1;
                end else begin
                    r_skip      <= 1'b0;
                    r_last_time <= i_time_value;
                    r_seen      <= 1'b1;
                end
            end
            if (load_out) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Request fields are captured once at acceptance; entries out of range get address zero.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_is_read  <= (i_req_type == REQ_READ);
            r_in_range <= in_range;
            r_addr     <= in_range ? ADDR_W'(32'(i_field_index) * NUM_POINTS
                                             + 32'(i_point_index)) : '0;
            r_bin      <= i_bin_index;
            r_sample   <= i_sample;
        end
        if (load_out) begin
            r_o_real <= re_link[NUM_BINS];
            r_o_imag <= im_link[NUM_BINS];
        end
    end

    rdft_trig #(
        .NUM_BINS      (NUM_BINS),
        .TRIG_ADDR_BITS(TRIG_ADDR_BITS)
    ) u_trig (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (trig_start),
        .i_time      (i_time_value),
        .i_freq_start(r_freq_start),
        .i_freq_step (r_freq_step),
        .o_push      (trig_push),
        .o_cos       (trig_cos),
        .o_sin       (trig_sin),
        .o_done      (trig_done)
    );

    // The head of the chain takes the request; new trig values enter at the tail
    // and shift toward cell 0, so after NUM_BINS pushes cell k holds bin k.
    assign cos_link[NUM_BINS] = trig_cos;
    assign sin_link[NUM_BINS] = trig_sin;
    assign tok_link[0]  = '{valid: (r_state == ST_LAUNCH), rd: r_is_read, hit: r_in_range};
    assign addr_link[0] = (r_state == ST_LAUNCH) ? r_addr : '0;
    assign bin_link[0]  = r_bin;
    assign smp_link[0]  = r_sample;
    assign re_link[0]   = '0;
    assign im_link[0]   = '0;

    for (genvar g = 0; g < NUM_BINS; g++) begin : g_cell
        rdft_cell #(
            .IDX   (g),
            .DEPTH (DEPTH),
            .ADDR_W(ADDR_W)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_load    (trig_push),
            .i_cos     (cos_link[g+1]),
            .i_sin     (sin_link[g+1]),
            .o_cos     (cos_link[g]),
            .o_sin     (sin_link[g]),
            .i_tok     (tok_link[g]),
            .i_addr    (addr_link[g]),
            .i_bin     (bin_link[g]),
            .i_sample  (smp_link[g]),
            .i_res_real(re_link[g]),
            .i_res_imag(im_link[g]),
            .o_tok     (tok_link[g+1]),
            .o_addr    (addr_link[g+1]),
            .o_bin     (bin_link[g+1]),
            .o_sample  (smp_link[g+1]),
            .o_res_real(re_link[g+1]),
            .o_res_imag(im_link[g+1]),
            .i_clr_en  (r_state == ST_CLEAR),
            .i_clr_addr(r_clr_addr)
        );
    end

    assign o_valid    = r_o_valid;
    assign o_real_sum = r_o_real;
    assign o_imag_sum = r_o_imag;

endmodule

// File: hdl/rdft_ram.sv
// Generic simple dual-port RAM with registered read.
module rdft_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 4096
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/rdft_trig.sv
// Sequenced phase and Q1.15 cosine/sine generator sharing one 32x32 multiplier.
module rdft_trig import rdft_pkg::*; #(
    parameter int NUM_BINS       = 8,
    parameter int TRIG_ADDR_BITS = 10
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [TIME_W-1:0]        i_time,
    input  logic [FREQ_W-1:0]        i_freq_start,
    input  logic [FREQ_W-1:0]        i_freq_step,
    output logic                     o_push,
    output logic signed [TRIG_W-1:0] o_cos,
    output logic signed [TRIG_W-1:0] o_sin,
    output logic                     o_done
);

    localparam int BIN_CW = NUM_BINS > 1 ? $clog2(NUM_BINS) : 1;
    localparam int R_W    = TRIG_ADDR_BITS - 2;

    t_trig_state         r_state, n_state;
    logic [31:0]         r_f;
    logic [31:0]         r_time;
    logic [31:0]         r_step;
    logic [BIN_CW-1:0]   r_bin;
    logic [63:0]         r_prod;
    logic [31:0]         r_phi;
    logic [31:0]         r_x2;
    logic [31:0]         r_h;
    logic [31:0]         r_p;
    logic [2:0]          r_idx;
    logic                r_is_sin;
    logic [1:0]          r_quad;
    logic [TRIG_W-1:0]   r_c;

    logic [31:0] m_a, m_b;
    logic [TRIG_ADDR_BITS-1:0] n_val;
    logic [7:0]  div_d;
    logic [31:0] q0;
    logic [39:0] rem;
    logic [32:0] t_q;
    logic [33:0] h_diff;
    logic [31:0] h_new;
    logic [TRIG_W-1:0] s_q15, c_q15;

    function automatic logic [TRIG_W-1:0] to_q15(input logic [31:0] v);
        logic [31:0] vc;
        logic [16:0] r;
        vc = (v > Q30_ONE) ? Q30_ONE : v;
        r  = 17'((vc + 32'd16384) >> 15);
        return (r > 17'd32767) ? 16'h7FFF : r[15:0];
    endfunction

    assign n_val  = r_prod[31 -: TRIG_ADDR_BITS];
    assign div_d  = horner_div(r_is_sin, r_idx);
    assign q0     = r_prod[63:32];
    assign rem    = {8'd0, r_p} - (40'(q0) * 40'(div_d));
    assign t_q    = (rem >= 40'(div_d)) ? (33'(q0) + 33'd1) : 33'(q0);
    assign h_diff = 34'(Q30_ONE) - 34'(t_q);
    assign h_new  = h_diff[33] ? 32'd0 : h_diff[31:0];
    assign s_q15  = to_q15(r_prod[61:30]);
    assign c_q15  = to_q15(h_new);

    always_comb begin
        n_state = r_state;
        m_a     = r_f;
        m_b     = r_time;
        o_push  = 1'b0;
        o_done  = 1'b0;
        unique case (r_state)
            TR_IDLE:  if (i_start) n_state = TR_FRAC;
            TR_FRAC:  n_state = TR_PHI;
            TR_PHI: begin
                m_a     = HALF_PI_Q30;
                m_b     = 32'(n_val[R_W-1:0]);
                n_state = TR_X2;
            end
            TR_X2: begin
                m_a     = r_prod[R_W +: 32];
                m_b     = r_prod[R_W +: 32];
                n_state = TR_HINIT;
            end
            TR_HINIT: n_state = TR_H_MUL;
            TR_H_MUL: begin
                m_a     = r_x2;
                m_b     = r_h;
                n_state = TR_H_REC;
            end
            TR_H_REC: begin
                m_a     = r_prod[61:30];
                m_b     = horner_recip(r_is_sin, r_idx);
                n_state = TR_H_COR;
            end
            TR_H_COR: begin
                if (r_idx == 3'd0 && r_is_sin) begin
                    n_state = TR_SMUL;
                end else begin
                    n_state = TR_H_MUL;
                end
            end
            TR_SMUL: begin
                m_a     = r_phi;
                m_b     = r_h;
                n_state = TR_OUT;
            end
            TR_OUT: begin
                o_push = 1'b1;
                if (r_bin == BIN_CW'(NUM_BINS - 1)) begin
                    o_done  = 1'b1;
                    n_state = TR_IDLE;
                end else begin
                    n_state = TR_FRAC;
                end
            end
            default: n_state = TR_IDLE;
        endcase
    end

    // Quadrant fold of the first-quadrant pair.
    always_comb begin
        case (r_quad)
            2'd0: begin o_cos = r_c;          o_sin = s_q15;        end
            2'd1: begin o_cos = -s_q15;       o_sin = r_c;          end
            2'd2: begin o_cos = -r_c;         o_sin = -s_q15;       end
            default: begin o_cos = s_q15;     o_sin = -r_c;         end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= TR_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= m_a * m_b;
        unique case (r_state)
            TR_IDLE: begin
                if (i_start) begin
                    r_f    <= i_freq_start;
                    r_step <= i_freq_step;
                    r_time <= i_time;
                    r_bin  <= '0;
                end
            end
            TR_PHI:   r_quad <= n_val[TRIG_ADDR_BITS-1 -: 2];
            TR_X2:    r_phi  <= r_prod[R_W +: 32];
            TR_HINIT: begin
                r_x2     <= r_prod[61:30];
                r_h      <= Q30_ONE;
                r_idx    <= COS_TERMS_LAST;
                r_is_sin <= 1'b0;
            end
            TR_H_REC: r_p <= r_prod[61:30];
            TR_H_COR: begin
                if (r_idx == 3'd0 && !r_is_sin) begin
                    r_c      <= c_q15;
                    r_h      <= Q30_ONE;
                    r_idx    <= SIN_TERMS_LAST;
                    r_is_sin <= 1'b1;
                end else begin
                    r_h   <= h_new;
                    r_idx <= r_idx - 3'd1;
                end
            end
            TR_OUT: begin
                r_f   <= r_f + r_step;
                r_bin <= r_bin + BIN_CW'(1);
            end
            default: ;
        endcase
    end

endmodule

// File: hdl/rdft_cell.sv
// One frequency-bin cell: trig store, accumulator RAM and a registered link stage.
module rdft_cell import rdft_pkg::*; #(
    parameter int IDX    = 0,
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = 12
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_load,
    input  logic signed [TRIG_W-1:0]    i_cos,
    input  logic signed [TRIG_W-1:0]    i_sin,
    output logic signed [TRIG_W-1:0]    o_cos,
    output logic signed [TRIG_W-1:0]    o_sin,
    input  t_tok                        i_tok,
    input  logic [ADDR_W-1:0]           i_addr,
    input  logic [BIN_IDX_W-1:0]        i_bin,
    input  logic signed [SAMPLE_W-1:0]  i_sample,
    input  logic signed [ACC_W-1:0]     i_res_real,
    input  logic signed [ACC_W-1:0]     i_res_imag,
    output t_tok                        o_tok,
    output logic [ADDR_W-1:0]           o_addr,
    output logic [BIN_IDX_W-1:0]        o_bin,
    output logic signed [SAMPLE_W-1:0]  o_sample,
    output logic signed [ACC_W-1:0]     o_res_real,
    output logic signed [ACC_W-1:0]     o_res_imag,
    input  logic                        i_clr_en,
    input  logic [ADDR_W-1:0]           i_clr_addr
);

    logic signed [TRIG_W-1:0]   r_cos, r_sin;
    t_tok                       r_tok;
    logic [ADDR_W-1:0]          r_addr;
    logic [BIN_IDX_W-1:0]       r_bin;
    logic signed [SAMPLE_W-1:0] r_sample;
    logic signed [ACC_W-1:0]    r_pr_re, r_pr_im;
    logic signed [ACC_W-1:0]    r_res_re, r_res_im;

    logic [2*ACC_W-1:0]         rdata, wdata;
    logic                       we;
    logic [ADDR_W-1:0]          waddr;
    logic signed [ACC_W-1:0]    acc_re, acc_im, sat_re, sat_im;

    function automatic logic signed [ACC_W-1:0] sat_add(input logic signed [ACC_W-1:0] a,
                                                        input logic signed [ACC_W-1:0] b);
        logic signed [ACC_W:0] s;
        s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
        if (s[ACC_W] != s[ACC_W-1]) begin
            return s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end
        return s[ACC_W-1:0];
    endfunction

    assign acc_re = rdata[2*ACC_W-1:ACC_W];
    assign acc_im = rdata[ACC_W-1:0];
    assign sat_re = sat_add(acc_re, r_pr_re);
    assign sat_im = sat_add(acc_im, r_pr_im);
    assign we     = i_clr_en || (r_tok.valid && !r_tok.rd);
    assign waddr  = i_clr_en ? i_clr_addr : r_addr;
    assign wdata  = i_clr_en ? '0 : {sat_re, sat_im};

    rdft_ram #(
        .WIDTH(2 * ACC_W),
        .DEPTH(DEPTH)
    ) u_acc_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(i_addr),
        .o_rdata(rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok <= i_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_cos <= i_cos;
            r_sin <= i_sin;
        end
        r_addr   <= i_addr;
        r_bin    <= i_bin;
        r_sample <= i_sample;
        // Operands are widened first so the full signed product is kept.
        r_pr_re  <= ACC_W'(i_sample) * ACC_W'(r_cos);
        r_pr_im  <= ACC_W'(i_sample) * ACC_W'(r_sin);
        if (r_tok.valid) begin
            if (r_tok.rd && r_tok.hit && 32'(r_bin) == IDX) begin
                r_res_re <= acc_re;
                r_res_im <= acc_im;
            end else begin
                r_res_re <= i_res_real;
                r_res_im <= i_res_imag;
            end
        end
    end

    assign o_cos      = r_cos;
    assign o_sin      = r_sin;
    assign o_tok      = r_tok;
    assign o_addr     = r_addr;
    assign o_bin      = r_bin;
    assign o_sample   = r_sample;
    assign o_res_real = r_res_re;
    assign o_res_imag = r_res_im;

endmodule

// File: test/running_dft_accumulator_unit_test.sv
// Self-checking testbench for the running DFT accumulator unit.
module running_dft_accumulator_unit_test;
    import rdft_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Config index that maps to no register; writes to it must be ignored.
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

    // Longest quiet stretches of the block: the clearing pass after reset,
    // the trig sequencer on a new step, the settle pause before a register
    // write and the long receiver hold.
    localparam int QUIET_LIMIT   = 20000;
    localparam int SETTLE_CYCLES = 500;
    localparam int LONG_HOLD     = 300;

    localparam int NBINS   = 8;
    localparam int NPOINTS = 1024;
    localparam int NFIELDS = 4;
    localparam int ENTRIES = NFIELDS * NPOINTS * NBINS;

    localparam longint SUM_MAX = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint SUM_MIN = -SUM_MAX - 1;
    localparam longint ONE_Q30 = 64'sd1073741824;

    typedef struct {
        logic                   req_type;
        logic                   first;
        logic [TIME_W-1:0]      time_value;
        logic [FIELD_IDX_W-1:0] field_index;
        logic [POINT_IDX_W-1:0] point_index;
        logic [BIN_IDX_W-1:0]   bin_index;
        logic signed [SAMPLE_W-1:0] sample;
    } dft_request_t;

    typedef struct {
        logic signed [ACC_W-1:0] real_sum;
        logic signed [ACC_W-1:0] imag_sum;
    } dft_sums_t;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_cfg_wr_en;
    logic [CFG_IDX_W-1:0]        i_cfg_index;
    logic [CFG_DATA_W-1:0]       i_cfg_data;
    logic                        i_valid;
    logic                        o_stall;
    logic [REQ_TYPE_W-1:0]       i_req_type;
    logic                        i_first_of_step;
    logic [TIME_W-1:0]           i_time_value;
    logic [FIELD_IDX_W-1:0]      i_field_index;
    logic [POINT_IDX_W-1:0]      i_point_index;
    logic [BIN_IDX_W-1:0]        i_bin_index;
    logic signed [SAMPLE_W-1:0]  i_sample;
    logic                        o_valid;
    logic                        i_stall;
    logic signed [ACC_W-1:0]     o_real_sum;
    logic signed [ACC_W-1:0]     o_imag_sum;

    running_dft_accumulator_unit dut (.*);

    // Model state: registers, step tracking, stored trig values and sums.
    logic [31:0]       model_freq_start;
    logic [31:0]       model_freq_step;
    logic [31:0]       model_last_time;
    logic              model_time_seen;
    logic              model_skip;
    logic signed [15:0] step_cos [NBINS];
    logic signed [15:0] step_sin [NBINS];
    longint            real_sums [ENTRIES];
    longint            imag_sums [ENTRIES];

    dft_sums_t expected_sums[$];

    int  error_count;
    int  requests_sent;
    int  effective_requests;
    int  reads_checked;
    int  steps_started;
    int  steps_skipped;
    int  saturations;
    int  burst_left;
    int  hold_left;
    int  quiet_cycles;
    int  stall_mode;
    int  mode_left;
    longint unsigned cycle_count;
    logic [POINT_IDX_W-1:0] point_pool [8];

    // Clock: 2 ns period.
    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // Q30 multiply with truncation; both operands are small and nonnegative.
    function automatic longint q30_mul(input longint a, input longint b);
        longint unsigned p;
        p = longint'(unsigned'(a)) * longint'(unsigned'(b));
        return longint'(p >> 30);
    endfunction

    // Horner evaluation of the truncated Taylor series of sin(x)/x or cos(x).
    function automatic longint taylor_series(input longint x2, input bit is_sin);
        longint sin_div [6];
        longint cos_div [7];
        longint h;
        longint t;
        int     count;
        sin_div = '{6, 20, 42, 72, 110, 156};
        cos_div = '{2, 12, 30, 56, 90, 132, 182};
        count = is_sin ? 6 : 7;
        h = ONE_Q30;
        for (int i = count - 1; i >= 0; i--) begin
            t = q30_mul(x2, h) / (is_sin ? sin_div[i] : cos_div[i]);
            h = ONE_Q30 - t;
            if (h < 0) h = 0;
        end
        return h;
    endfunction

    function automatic logic signed [15:0] q30_to_q15(input longint v);
        longint r;
        if (v < 0) v = 0;
        if (v > ONE_Q30) v = ONE_Q30;
        r = (v + 64'sd16384) >>> 15;
        if (r > 32767) r = 32767;
        return 16'(r);
    endfunction

    // Cosine and sine of 2*pi*frac, first quadrant by series, then folded.
    task automatic phase_trig(input logic [31:0] frac,
                              output logic signed [15:0] c_out,
                              output logic signed [15:0] s_out);
        logic [9:0]  n;
        longint      phi;
        longint      x2;
        logic signed [15:0] c;
        logic signed [15:0] s;
        n   = frac[31:22];
        phi = longint'((64'd1686629713 * longint'(n[7:0])) >> 8);
        x2  = q30_mul(phi, phi);
        s   = q30_to_q15(q30_mul(phi, taylor_series(x2, 1'b1)));
        c   = q30_to_q15(taylor_series(x2, 1'b0));
        case (n[9:8])
            2'd0: begin c_out = c;  s_out = s;  end
            2'd1: begin c_out = -s; s_out = c;  end
            2'd2: begin c_out = -c; s_out = -s; end
            default: begin c_out = s; s_out = -c; end
        endcase
    endtask

    function automatic longint saturating_add(input longint a, input longint b);
        longint s;
        s = a + b;
        if (s > SUM_MAX) begin
            saturations++;
            return SUM_MAX;
        end
        if (s < SUM_MIN) begin
            saturations++;
            return SUM_MIN;
        end
        return s;
    endfunction

    // Applies one accepted request to the model; a read queues its sums.
    task automatic apply_request(input dft_request_t r);
        int          base;
        logic [31:0] f;
        logic [63:0] prod;
        dft_sums_t   sums;
        base = (int'(r.field_index) * NPOINTS + int'(r.point_index)) * NBINS;
        if (r.req_type == REQ_READ) begin
            sums.real_sum = real_sums[base + r.bin_index][47:0];
            sums.imag_sum = imag_sums[base + r.bin_index][47:0];
            expected_sums.push_back(sums);
            effective_requests++;
        end else begin
            if (r.first) begin
                if (model_time_seen && r.time_value == model_last_time) begin
                    model_skip = 1'b1;
                    steps_skipped++;
                end else begin
                    model_skip      = 1'b0;
                    model_last_time = r.time_value;
                    model_time_seen = 1'b1;
                    steps_started++;
                    for (int k = 0; k < NBINS; k++) begin
                        f    = model_freq_start + 32'(k) * model_freq_step;
                        prod = 64'(f) * 64'(r.time_value);
                        phase_trig(prod[31:0], step_cos[k], step_sin[k]);
                    end
                end
            end
            if (!model_skip) begin
                effective_requests++;
                for (int k = 0; k < NBINS; k++) begin
                    real_sums[base + k] = saturating_add(real_sums[base + k],
                        longint'(r.sample) * longint'(step_cos[k]));
                    imag_sums[base + k] = saturating_add(imag_sums[base + k],
                        longint'(r.sample) * longint'(step_sin[k]));
                end
            end
        end
    endtask

    task automatic report_mismatch(input string what, input logic [47:0] got,
                                   input logic [47:0] want);
        error_count++;
        $display("mismatch on %s at cycle %0d: got %h, expected %h",
                 what, cycle_count, got, want);
    endtask

    // Result checker: each accepted result is compared with the oldest one queued.
    always @(posedge i_clk) begin
        dft_sums_t want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_sums.size() == 0) begin
                error_count++;
                $display("unexpected result at cycle %0d: %h %h",
                         cycle_count, o_real_sum, o_imag_sum);
            end else begin
                want = expected_sums.pop_front();
                reads_checked++;
                if (o_real_sum !== want.real_sum)
                    report_mismatch("real_sum", o_real_sum, want.real_sum);
                if (o_imag_sum !== want.imag_sum)
                    report_mismatch("imag_sum", o_imag_sum, want.imag_sum);
            end
        end
    end

    // Watchdog: the run ends if no handshake happens on either side for too long.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog expired after %0d quiet cycles", quiet_cycles);
            $display("FAIL");
            $finish;
        end
    end

    // Receiver back-pressure: a pattern that changes mode now and then, plus
    // a long hold whenever hold_left is loaded by a test.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_stall   <= 1'b1;
            hold_left <= hold_left - 1;
        end else begin
            case (stall_mode)
                0: i_stall <= 1'b0;
                1: i_stall <= ($urandom_range(99) < 30);
                2: i_stall <= ((cycle_count % 5) < 2);
                default: i_stall <= ($urandom_range(99) < 75);
            endcase
        end
        if (mode_left == 0) begin
            stall_mode <= $urandom_range(3);
            mode_left  <= $urandom_range(400, 20);
        end else begin
            mode_left <= mode_left - 1;
        end
    end

    // Sends one request, waits for it to be taken, then maybe opens a gap.
    // Called at a falling edge and returns at a falling edge.
    task automatic send_request(input dft_request_t r);
        i_req_type      = r.req_type;
        i_first_of_step = r.first;
        i_time_value    = r.time_value;
        i_field_index   = r.field_index;
        i_point_index   = r.point_index;
        i_bin_index     = r.bin_index;
        i_sample        = r.sample;
        i_valid         = 1'b1;
        do @(posedge i_clk); while (o_stall);
        apply_request(r);
        requests_sent++;
        @(negedge i_clk);
        if (burst_left == 0) begin
            i_valid = 1'b0;
            repeat ($urandom_range(6, 1)) @(negedge i_clk);
            burst_left = ($urandom_range(9) == 0) ? $urandom_range(120, 40)
                                                  : $urandom_range(8);
        end else begin
            burst_left--;
        end
    endtask

    function automatic dft_request_t accum_request(input logic first,
            input logic [31:0] t, input logic [1:0] f, input logic [9:0] p,
            input logic [31:0] smp);
        dft_request_t r;
        r.req_type    = REQ_ACCUM;
        r.first       = first;
        r.time_value  = t;
        r.field_index = f;
        r.point_index = p;
        r.bin_index   = 3'($urandom);
        r.sample      = smp;
        return r;
    endfunction

    // Read flags other than the entry and bin carry random junk on purpose.
    function automatic dft_request_t read_request(input logic [1:0] f,
            input logic [9:0] p, input logic [2:0] b);
        dft_request_t r;
        r.req_type    = REQ_READ;
        r.first       = 1'($urandom);
        r.time_value  = $urandom;
        r.field_index = f;
        r.point_index = p;
        r.bin_index   = b;
        r.sample      = $urandom;
        return r;
    endfunction

    // Reads all eight bins of one entry.
    task automatic read_entry(input logic [1:0] f, input logic [9:0] p);
        for (int b = 0; b < NBINS; b++) send_request(read_request(f, p, 3'(b)));
    endtask

    // Register write: the block must be idle, so drain and let a trig pass finish.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        i_valid = 1'b0;
        wait (expected_sums.size() == 0);
        @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        i_cfg_wr_en = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = value;
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
        if (idx == REG_FREQ_START) model_freq_start = value;
        else if (idx == REG_FREQ_STEP) model_freq_step = value;
    endtask

    task automatic set_frequencies(input logic [31:0] start, input logic [31:0] spacing);
        write_register(REG_FREQ_START, start);
        write_register(REG_FREQ_STEP, spacing);
    endtask

    // Writes after reset, including one to an unmapped index that must do nothing.
    task automatic test_register_writes();
        write_register(REG_UNMAPPED, 32'hDEAD_BEEF);
        set_frequencies(32'h0001_0000, 32'h0000_4000);
    endtask

    // Field extremes with a bin-0 frequency of 1 and a quarter-cycle spacing.
    task automatic test_field_extremes();
        send_request(accum_request(1'b1, 32'h0000_0000, 2'd0, 10'd0, 32'h7FFF_FFFF));
        send_request(accum_request(1'b0, 32'h0000_0000, 2'd3, 10'd1023, 32'h8000_0000));
        send_request(accum_request(1'b1, 32'hFFFF_FFFF, 2'd1, 10'd5, 32'h0001_0000));
        send_request(accum_request(1'b0, 32'h1234_5678, 2'd2, 10'd512, 32'hFFFF_FFFF));
        send_request(accum_request(1'b1, 32'h0000_6000, 2'd0, 10'd0, 32'h0000_0001));
        read_entry(2'd0, 10'd0);
        send_request(read_request(2'd3, 10'd1023, 3'd7));
        send_request(read_request(2'd1, 10'd5, 3'd3));
        send_request(read_request(2'd2, 10'd512, 3'd0));
    endtask

    // A first request with the time of the previous step skips the whole step.
    task automatic test_repeated_step();
        send_request(accum_request(1'b1, 32'h0000_6000, 2'd1, 10'd9, 32'h0003_0000));
        send_request(accum_request(1'b0, 32'h0000_6000, 2'd1, 10'd9, 32'h0007_0000));
        send_request(accum_request(1'b1, 32'h0000_7000, 2'd1, 10'd9, 32'h0002_0000));
        send_request(read_request(2'd1, 10'd9, 3'd2));
    endtask

    // Zero frequency gives cos = full scale, so a few full-range samples saturate.
    task automatic test_saturation();
        set_frequencies(32'h0000_0000, 32'h0000_0000);
        send_request(accum_request(1'b1, 32'h0000_1000, 2'd2, 10'd77, 32'h7FFF_FFFF));
        repeat (5) send_request(accum_request(1'b0, 32'h0, 2'd2, 10'd77, 32'h7FFF_FFFF));
        repeat (6) send_request(accum_request(1'b0, 32'h0, 2'd3, 10'd78, 32'h8000_0000));
        send_request(read_request(2'd2, 10'd77, 3'd4));
        send_request(read_request(2'd3, 10'd78, 3'd6));
    endtask

    // The receiver holds off while reads keep coming, so the output fills and
    // the input stalls; then the sender waits for every result to drain.
    task automatic test_backpressure();
        hold_left = LONG_HOLD;
        for (int i = 0; i < 20; i++)
            send_request(read_request(2'($urandom), point_pool[i % 8], 3'($urandom)));
        i_valid = 1'b0;
        wait (expected_sums.size() == 0);
        @(negedge i_clk);
    endtask

    // Well-formed steps with random content, broken by repeated step times and
    // reads mixed in, under one frequency setting.
    task automatic random_phase(input int quota);
        logic [31:0] step_time;
        logic [31:0] smp;
        logic [9:0]  p;
        int          target;
        step_time = $urandom;
        target    = effective_requests + quota;
        while (effective_requests < target) begin
            case ($urandom_range(9))
                0: ;
                1, 2: step_time = $urandom;
                default: step_time = step_time + $urandom_range(4096, 1);
            endcase
            send_request(accum_request(1'b1, step_time, 2'($urandom),
                                       point_pool[$urandom_range(7)], $urandom));
            repeat ($urandom_range(8)) begin
                p   = ($urandom_range(4) == 0) ? 10'($urandom) : point_pool[$urandom_range(7)];
                smp = ($urandom_range(3) == 0) ? $urandom
                                               : 32'($signed(20'($urandom)));
                if ($urandom_range(9) < 3)
                    send_request(read_request(2'($urandom), point_pool[$urandom_range(7)],
                                              3'($urandom)));
                else
                    send_request(accum_request(1'b0, step_time, 2'($urandom), p, smp));
            end
        end
    endtask

    task automatic test_random_traffic();
        for (int i = 0; i < 8; i++) point_pool[i] = 10'($urandom);
        set_frequencies($urandom, $urandom);
        random_phase(450);
        set_frequencies(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        random_phase(300);
        set_frequencies(32'h0000_8000, 32'h0000_2000);
        random_phase(300);
        set_frequencies($urandom, 32'($urandom_range(65535)));
        random_phase(250);
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_cfg_wr_en     = 1'b0;
        i_cfg_index     = REG_FREQ_START;
        i_cfg_data      = '0;
        i_valid         = 1'b0;
        i_stall         = 1'b0;
        i_req_type      = REQ_ACCUM;
        i_first_of_step = 1'b0;
        i_time_value    = '0;
        i_field_index   = '0;
        i_point_index   = '0;
        i_bin_index     = '0;
        i_sample        = '0;
        model_freq_start = '0;
        model_freq_step  = '0;
        model_last_time  = '0;
        model_time_seen  = 1'b0;
        model_skip       = 1'b0;
        foreach (real_sums[i]) begin
            real_sums[i] = 0;
            imag_sums[i] = 0;
        end
        foreach (point_pool[i]) point_pool[i] = 10'(i * 3);
        error_count = 0;
        requests_sent = 0;
        effective_requests = 0;
        reads_checked = 0;
        steps_started = 0;
        steps_skipped = 0;
        saturations = 0;
        burst_left = 0;
        hold_left = 0;
        quiet_cycles = 0;
        stall_mode = 0;
        mode_left = 50;
        cycle_count = 0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_register_writes();
        test_field_extremes();
        test_repeated_step();
        test_saturation();
        test_backpressure();
        test_random_traffic();

        i_valid = 1'b0;
        wait (expected_sums.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Sent %0d requests (%0d effective), checked %0d reads.",
                 requests_sent, effective_requests, reads_checked);
        $display("Steps started %0d, steps skipped %0d, saturating adds %0d.",
                 steps_started, steps_skipped, saturations);
        if (error_count == 0 && expected_sums.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
